// ===== src/imhdk_pkg.sv =====
// Shared types and constants for the indexed min-heap with decrease-key.
// Used by the controller, the datapath, the top level and the checker.
package imhdk_pkg;

  localparam int ID_W   = 12;
  localparam int PRIO_W = 32;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DECREASED = 3'd1,
    ST_IGNORED   = 3'd2,
    ST_FULL      = 3'd3,
    ST_PULLED    = 3'd4,
    ST_EMPTY     = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_DEC_CHK,
    S_UP,
    S_UP_CMP,
    S_DOWN,
    S_DOWN_CMP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]          id;
    logic signed [PRIO_W-1:0] prio;
  } heap_entry_t;

  typedef struct packed {
    logic    accept;
    logic    clr_step;
    logic    load_at;
    logic    rd_parent;
    logic    rd_child;
    logic    ins_new;
    logic    set_cur;
    logic    up_move;
    logic    down_move;
    logic    final_wr;
    logic    pull_take;
    logic    status_we;
    status_t status;
    logic    finish;
  } dp_cmd_t;

  typedef struct packed {
    logic func;
    logic oob;
    logic pos_valid;
    logic full;
    logic empty;
    logic last_one;
    logic not_lower;
    logic at_root;
    logic parent_greater;
    logic has_child;
    logic child_smaller;
    logic clr_done;
  } dp_sts_t;

endpackage

// ===== src/imhdk_ctrl.sv =====
// Controller state machine of the indexed min-heap.
// Depends on imhdk_pkg for the state, command and status types.
module imhdk_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  imhdk_pkg::dp_sts_t sts,
  output imhdk_pkg::dp_cmd_t cmd,
  output logic               busy
);

  imhdk_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= imhdk_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      imhdk_pkg::S_CLEAR: begin
        if (sts.clr_done) state_nxt = imhdk_pkg::S_IDLE;
      end
      imhdk_pkg::S_IDLE: begin
        if (start) state_nxt = imhdk_pkg::S_DISPATCH;
      end
      imhdk_pkg::S_DISPATCH: begin
        if (!sts.func) begin
          if (sts.oob) state_nxt = imhdk_pkg::S_DONE;
          else if (sts.pos_valid) state_nxt = imhdk_pkg::S_DEC_CHK;
          else if (sts.full) state_nxt = imhdk_pkg::S_DONE;
          else state_nxt = imhdk_pkg::S_UP;
        end else begin
          if (sts.empty || sts.last_one) state_nxt = imhdk_pkg::S_DONE;
          else state_nxt = imhdk_pkg::S_DOWN;
        end
      end
      imhdk_pkg::S_DEC_CHK: begin
        state_nxt = sts.not_lower ? imhdk_pkg::S_DONE : imhdk_pkg::S_UP;
      end
      imhdk_pkg::S_UP: begin
        state_nxt = sts.at_root ? imhdk_pkg::S_DONE : imhdk_pkg::S_UP_CMP;
      end
      imhdk_pkg::S_UP_CMP: begin
        state_nxt = sts.parent_greater ? imhdk_pkg::S_UP : imhdk_pkg::S_DONE;
      end
      imhdk_pkg::S_DOWN: begin
        state_nxt = sts.has_child ? imhdk_pkg::S_DOWN_CMP : imhdk_pkg::S_DONE;
      end
      imhdk_pkg::S_DOWN_CMP: begin
        state_nxt = sts.child_smaller ? imhdk_pkg::S_DOWN : imhdk_pkg::S_DONE;
      end
      imhdk_pkg::S_DONE: begin
        state_nxt = imhdk_pkg::S_IDLE;
      end
      default: state_nxt = imhdk_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.status = imhdk_pkg::ST_IGNORED;
    busy       = 1'b1;
    unique case (state_r)
      imhdk_pkg::S_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      imhdk_pkg::S_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
      end
      imhdk_pkg::S_DISPATCH: begin
        cmd.status_we = 1'b1;
        if (!sts.func) begin
          if (sts.oob) begin
            cmd.status = imhdk_pkg::ST_IGNORED;
          end else if (sts.pos_valid) begin
            cmd.status_we = 1'b0;
            cmd.load_at   = 1'b1;
          end else if (sts.full) begin
            cmd.status = imhdk_pkg::ST_FULL;
          end else begin
            cmd.status  = imhdk_pkg::ST_INSERTED;
            cmd.ins_new = 1'b1;
          end
        end else begin
          if (sts.empty) begin
            cmd.status = imhdk_pkg::ST_EMPTY;
          end else begin
            cmd.status    = imhdk_pkg::ST_PULLED;
            cmd.pull_take = 1'b1;
          end
        end
      end
      imhdk_pkg::S_DEC_CHK: begin
        cmd.status_we = 1'b1;
        if (sts.not_lower) begin
          cmd.status = imhdk_pkg::ST_IGNORED;
        end else begin
          cmd.status  = imhdk_pkg::ST_DECREASED;
          cmd.set_cur = 1'b1;
        end
      end
      imhdk_pkg::S_UP: begin
        if (sts.at_root) cmd.final_wr = 1'b1;
        else cmd.rd_parent = 1'b1;
      end
      imhdk_pkg::S_UP_CMP: begin
        if (sts.parent_greater) cmd.up_move = 1'b1;
        else cmd.final_wr = 1'b1;
      end
      imhdk_pkg::S_DOWN: begin
        if (sts.has_child) cmd.rd_child = 1'b1;
        else cmd.final_wr = 1'b1;
      end
      imhdk_pkg::S_DOWN_CMP: begin
        if (sts.child_smaller) cmd.down_move = 1'b1;
        else cmd.final_wr = 1'b1;
      end
      imhdk_pkg::S_DONE: begin
        cmd.finish = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== src/imhdk_datapath.sv =====
// Datapath of the indexed min-heap: heap store, position table and registers.
// Depends on imhdk_pkg; driven by commands from imhdk_ctrl.
module imhdk_datapath #(
  parameter int HEAP_DEPTH = 1024,
  parameter int ID_COUNT   = 4096,
  parameter int CW         = $clog2(HEAP_DEPTH + 1)
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  imhdk_pkg::dp_cmd_t                    cmd,
  input  logic                                  in_func,
  input  logic [imhdk_pkg::ID_W-1:0]            in_element_id,
  input  logic signed [imhdk_pkg::PRIO_W-1:0]   in_priority_req,
  output imhdk_pkg::dp_sts_t                    sts,
  output logic                                  out_valid,
  output logic [2:0]                            out_status,
  output logic [imhdk_pkg::ID_W-1:0]            out_id,
  output logic signed [imhdk_pkg::PRIO_W-1:0]   out_prio,
  output logic [CW-1:0]                         out_count
);

  localparam int HW = $clog2(HEAP_DEPTH);
  localparam int IW = $clog2(ID_COUNT);
  localparam int XW = HW + 2;

  imhdk_pkg::heap_entry_t heap_mem [HEAP_DEPTH];
  logic [HW:0]            pos_mem  [ID_COUNT];

  imhdk_pkg::heap_entry_t rd_a_r, rd_b_r, cur_r, dest;
  logic [HW:0]            pos_rd_r;
  logic [HW-1:0]          addr_a, addr_b, at_r, parent, dest_idx;
  logic [CW-1:0]          count_r;
  logic [IW-1:0]          clr_cnt_r;
  logic                   req_func_r;
  logic [imhdk_pkg::ID_W-1:0]          req_id_r, res_id_r;
  logic signed [imhdk_pkg::PRIO_W-1:0] req_prio_r, res_prio_r;
  imhdk_pkg::status_t     status_r;
  logic                   out_valid_r;
  logic [2:0]             out_status_r;
  logic [imhdk_pkg::ID_W-1:0]          out_id_r;
  logic signed [imhdk_pkg::PRIO_W-1:0] out_prio_r;
  logic [CW-1:0]          out_count_r;

  logic [XW-1:0] child_a, child_b, count_x;
  logic          pick_b;

  logic                   heap_we, pos_we;
  imhdk_pkg::heap_entry_t heap_wdata;
  logic [IW-1:0]          pos_waddr;
  logic [HW:0]            pos_wdata;

  assign parent  = (at_r - HW'(1)) >> 1;
  assign child_a = {1'b0, at_r, 1'b1};
  assign child_b = {1'b0, at_r, 1'b0} + XW'(2);
  assign count_x = XW'(count_r);
  assign pick_b  = (child_b < count_x) && !(rd_a_r.prio < rd_b_r.prio);
  assign dest     = pick_b ? rd_b_r : rd_a_r;
  assign dest_idx = pick_b ? child_b[HW-1:0] : child_a[HW-1:0];

  always_comb begin
    if (cmd.load_at) addr_a = pos_rd_r[HW-1:0];
    else if (cmd.rd_parent) addr_a = parent;
    else if (cmd.rd_child) addr_a = child_a[HW-1:0];
    else addr_a = '0;
    addr_b = cmd.rd_child ? child_b[HW-1:0] : HW'(count_r - CW'(1));
  end

  // Write ports: the moving entry is held in cur_r and written once, at its final slot.
  always_comb begin
    heap_we    = cmd.up_move | cmd.down_move | cmd.final_wr;
    heap_wdata = cur_r;
    if (cmd.up_move) heap_wdata = rd_a_r;
    else if (cmd.down_move) heap_wdata = dest;
    pos_we    = heap_we | cmd.clr_step | cmd.pull_take;
    pos_waddr = IW'(cur_r.id);
    pos_wdata = {1'b1, at_r};
    if (cmd.clr_step) begin
      pos_waddr = clr_cnt_r;
      pos_wdata = '0;
    end else if (cmd.pull_take) begin
      pos_waddr = IW'(rd_a_r.id);
      pos_wdata = '0;
    end else if (cmd.up_move) begin
      pos_waddr = IW'(rd_a_r.id);
    end else if (cmd.down_move) begin
      pos_waddr = IW'(dest.id);
    end
  end

  always_ff @(posedge clk) begin
    rd_a_r   <= heap_mem[addr_a];
    rd_b_r   <= heap_mem[addr_b];
    pos_rd_r <= pos_mem[IW'(in_element_id)];
    if (heap_we) heap_mem[at_r] <= heap_wdata;
    if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + IW'(1);
      if (cmd.ins_new) count_r <= count_r + CW'(1);
      if (cmd.pull_take) count_r <= count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_func_r <= in_func;
      req_id_r   <= in_element_id;
      req_prio_r <= in_priority_req;
      res_id_r   <= '0;
      res_prio_r <= '0;
    end
    if (cmd.load_at) at_r <= pos_rd_r[HW-1:0];
    if (cmd.ins_new) begin
      at_r  <= HW'(count_r);
      cur_r <= {req_id_r, req_prio_r};
    end
    if (cmd.set_cur) cur_r <= {req_id_r, req_prio_r};
    if (cmd.up_move) at_r <= parent;
    if (cmd.down_move) at_r <= dest_idx;
    if (cmd.pull_take) begin
      res_id_r   <= rd_a_r.id;
      res_prio_r <= rd_a_r.prio;
      cur_r      <= rd_b_r;
      at_r       <= '0;
    end
    if (cmd.status_we) status_r <= cmd.status;
    if (cmd.finish) begin
      out_status_r <= status_r;
      out_id_r     <= res_id_r;
      out_prio_r   <= res_prio_r;
      out_count_r  <= count_r;
    end
  end

  always_comb begin
    sts.func           = req_func_r;
    sts.oob            = 32'(req_id_r) >= ID_COUNT;
    sts.pos_valid      = pos_rd_r[HW];
    sts.full           = 32'(count_r) >= HEAP_DEPTH;
    sts.empty          = count_r == '0;
    sts.last_one       = count_r == CW'(1);
    sts.not_lower      = rd_a_r.prio <= req_prio_r;
    sts.at_root        = at_r == '0;
    sts.parent_greater = rd_a_r.prio > cur_r.prio;
    sts.has_child      = child_a < count_x;
    sts.child_smaller  = dest.prio < cur_r.prio;
    sts.clr_done       = clr_cnt_r == IW'(ID_COUNT - 1);
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_id     = out_id_r;
  assign out_prio   = out_prio_r;
  assign out_count  = out_count_r;

endmodule

// ===== src/indexed_min_heap_decrease_key.sv =====
// Top level of the indexed binary min-heap with decrease-key.
// Instantiates imhdk_ctrl and imhdk_datapath; types come from imhdk_pkg.
//
// Usage: a command beat is taken at a rising edge where start is high and
// busy is low. in_func selects insert-or-decrease (0) or pull-minimum (1);
// in_element_id and in_priority_req carry the id and its new priority.
// Exactly one result beat follows each command: out_valid is high for one
// cycle with out_status, out_id, out_prio and out_count. The receiver
// cannot stall, so the result must be captured in that cycle.
// The time that a command takes is set by the sift loop, which reads and then
// writes the single heap memory once per heap level that the entry moves. A
// new command may be given in the cycle the result shows.
// Reset: after rst_n is released the position table is swept clear, one id
// per cycle, for ID_COUNT cycles; busy stays high meanwhile. The heap count
// resets to zero; heap slots hold nothing meaningful until written.
module indexed_min_heap_decrease_key #(
  parameter int HEAP_DEPTH = 1024,
  parameter int ID_COUNT   = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_func,
  input  logic [imhdk_pkg::ID_W-1:0]          in_element_id,
  input  logic signed [imhdk_pkg::PRIO_W-1:0] in_priority_req,
  output logic                                out_valid,
  output logic [2:0]                          out_status,
  output logic [imhdk_pkg::ID_W-1:0]          out_id,
  output logic signed [imhdk_pkg::PRIO_W-1:0] out_prio,
  output logic [$clog2(HEAP_DEPTH+1)-1:0]     out_count
);

  // Commands flow from the controller to the datapath, flags flow back.
  imhdk_pkg::dp_cmd_t cmd;
  imhdk_pkg::dp_sts_t sts;

  imhdk_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  imhdk_datapath #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .ID_COUNT   (ID_COUNT),
    .CW         ($clog2(HEAP_DEPTH + 1))
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_func         (in_func),
    .in_element_id   (in_element_id),
    .in_priority_req (in_priority_req),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_id          (out_id),
    .out_prio        (out_prio),
    .out_count       (out_count)
  );

endmodule

// ===== src/imhdk_checker.sv =====
// Port-level checker for the indexed min-heap, bound to the top level.
// Depends on imhdk_pkg for the status codes.
module imhdk_checker #(
  parameter int CW = 11
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic                                out_valid,
  input logic [2:0]                          out_status,
  input logic [imhdk_pkg::ID_W-1:0]          out_id,
  input logic signed [imhdk_pkg::PRIO_W-1:0] out_prio,
  input logic [CW-1:0]                       out_count
);

  a_no_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid) else $error("result right after accept");

  a_single_cycle_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= 3'(imhdk_pkg::ST_EMPTY))) else $error("bad status");

  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != 3'(imhdk_pkg::ST_PULLED)) |->
      (out_id == '0 && out_prio == '0)) else $error("payload not zero");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == 3'(imhdk_pkg::ST_EMPTY)) |-> (out_count == '0))
    else $error("empty with nonzero count");

endmodule

bind indexed_min_heap_decrease_key imhdk_checker #(
  .CW ($clog2(HEAP_DEPTH + 1))
) u_imhdk_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_status (out_status),
  .out_id     (out_id),
  .out_prio   (out_prio),
  .out_count  (out_count)
);

// ===== dv/tb_indexed_min_heap_decrease_key.sv =====
// Self-checking testbench for the indexed min-heap with decrease-key.
// Depends on imhdk_pkg and the indexed_min_heap_decrease_key top level.
module tb_indexed_min_heap_decrease_key;

  localparam int DEPTH   = 1024;
  localparam int IDS     = 4096;
  localparam int IDW     = imhdk_pkg::ID_W;
  localparam int PW      = imhdk_pkg::PRIO_W;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int LIMIT   = 2000000;

  // Expected outcome of one command beat.
  typedef struct {
    imhdk_pkg::status_t status;
    logic [IDW-1:0]     id;
    logic signed [31:0] prio;
    logic [CNT_W-1:0]   count;
  } heap_result_t;

  // Scoreboard: a mirror of the heap and a queue of pending outcomes.
  class heap_scoreboard;
    logic signed [31:0] prios[DEPTH];
    logic [IDW-1:0]     ids[DEPTH];
    bit                 present[IDS];
    int                 slot_of[IDS];
    int                 fill;
    heap_result_t       pending[$];
    int                 errors;

    function void swap_slots(int x, int y);
      logic signed [31:0] tp;
      logic [IDW-1:0]     ti;
      tp = prios[x]; ti = ids[x];
      prios[x] = prios[y]; ids[x] = ids[y];
      prios[y] = tp; ids[y] = ti;
      slot_of[ids[x]] = x;
      slot_of[ids[y]] = y;
    endfunction

    function void rise(int at);
      int up;
      while (at > 0) begin
        up = (at - 1) / 2;
        if (prios[up] > prios[at]) begin
          swap_slots(up, at);
          at = up;
        end else break;
      end
    endfunction

    function void sink(int at);
      int a, b, dest;
      forever begin
        a = 2 * at + 1;
        b = 2 * at + 2;
        if (a >= fill) break;
        // On equal children the right one is taken.
        dest = (b >= fill || prios[a] < prios[b]) ? a : b;
        if (prios[dest] < prios[at]) begin
          swap_slots(at, dest);
          at = dest;
        end else break;
      end
    endfunction

    // Notes an accepted command and queues the outcome it must produce.
    function void note_command(logic func, logic [IDW-1:0] id, logic signed [31:0] p);
      heap_result_t r;
      int at;
      r.id = '0;
      r.prio = '0;
      if (func == 1'b0) begin
        if (present[id]) begin
          at = slot_of[id];
          if (prios[at] <= p) r.status = imhdk_pkg::ST_IGNORED;
          else begin
            prios[at] = p;
            rise(at);
            r.status = imhdk_pkg::ST_DECREASED;
          end
        end else if (fill >= DEPTH) r.status = imhdk_pkg::ST_FULL;
        else begin
          at = fill;
          ids[at] = id;
          prios[at] = p;
          present[id] = 1'b1;
          slot_of[id] = at;
          fill++;
          rise(at);
          r.status = imhdk_pkg::ST_INSERTED;
        end
      end else begin
        if (fill == 0) r.status = imhdk_pkg::ST_EMPTY;
        else begin
          r.id = ids[0];
          r.prio = prios[0];
          present[ids[0]] = 1'b0;
          fill--;
          if (fill > 0) begin
            ids[0] = ids[fill];
            prios[0] = prios[fill];
            slot_of[ids[0]] = 0;
            sink(0);
          end
          r.status = imhdk_pkg::ST_PULLED;
        end
      end
      r.count = CNT_W'(fill);
      pending.push_back(r);
    endfunction

    // Compares one result beat with the oldest pending outcome.
    function void check_result(logic [2:0] st, logic [IDW-1:0] id,
                               logic signed [31:0] p, logic [CNT_W-1:0] c);
      heap_result_t e;
      if (pending.size() == 0) begin
        $error("result beat with nothing pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, st); errors++;
      end
      if (id !== e.id) begin
        $error("out_id: expected %0d, actual %0d", e.id, id); errors++;
      end
      if (p !== e.prio) begin
        $error("out_prio: expected %0d, actual %0d", e.prio, p); errors++;
      end
      if (c !== e.count) begin
        $error("out_count: expected %0d, actual %0d", e.count, c); errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 in_func = 1'b0;
  logic [IDW-1:0]       in_element_id = '0;
  logic signed [PW-1:0] in_priority_req = '0;
  logic                 out_valid;
  logic [2:0]           out_status;
  logic [IDW-1:0]       out_id;
  logic signed [PW-1:0] out_prio;
  logic [CNT_W-1:0]     out_count;

  heap_scoreboard board = new();
  int cycles = 0;

  always #6 clk = ~clk;

  indexed_min_heap_decrease_key #(.HEAP_DEPTH(DEPTH), .ID_COUNT(IDS)) uut (.*);

  // Result beats cannot be held off, so every strobe is checked on the spot.
  always @(posedge clk) begin
    if (rst_n && out_valid)
      board.check_result(out_status, out_id, out_prio, out_count);
  end

  // Watchdog: the reset sweep plus worst-case latency per command fits easily.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(10, 60));
  endfunction

  // Presents one command beat and holds it until busy is low at an edge.
  // Start is only dropped when an idle gap follows, so it is never pulsed
  // low and high within one time step.
  task automatic send_command(logic func, logic [IDW-1:0] id, logic signed [31:0] p,
                              bit gap);
    int n;
    n = gap ? idle_len() : 0;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
    start <= 1'b1;
    in_func <= func;
    in_element_id <= id;
    in_priority_req <= p;
    do @(posedge clk); while (busy !== 1'b0);
    board.note_command(func, id, p);
  endtask

  // Priorities favour a narrow band so that ties and decreases occur,
  // with full-range values and the extremes mixed in.
  function automatic logic signed [31:0] pick_priority();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $signed($urandom_range(0, 40)) - 20;
    if (r < 6) return ($urandom_range(0, 1) == 0) ? 32'sh7fffffff : 32'sh80000000;
    return $urandom();
  endfunction

  initial begin
    int n;
    int live;
    bit f;
    logic [IDW-1:0] id;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty pull, extremes of id and priority, decrease, equal and
    // higher priority ignored, ties broken towards the right child.
    send_command(1'b1, '0, '0, 1'b0);
    send_command(1'b0, 12'd0, 32'sh7fffffff, 1'b0);
    send_command(1'b0, 12'd4095, 32'sh80000000, 1'b0);
    send_command(1'b0, 12'd0, 32'sh7fffffff, 1'b0);
    send_command(1'b0, 12'd0, 32'sh7ffffffe, 1'b1);
    send_command(1'b0, 12'd4095, 32'sh7fffffff, 1'b0);
    send_command(1'b0, 12'd5, 32'sd10, 1'b0);
    send_command(1'b0, 12'd6, 32'sd10, 1'b0);
    send_command(1'b0, 12'd7, 32'sd10, 1'b1);
    send_command(1'b0, 12'd7, -32'sd50, 1'b0);
    send_command(1'b0, 12'd2730, 32'sh55555555, 1'b0);
    send_command(1'b0, 12'd1365, -32'sh55555556, 1'b0);
    for (int k = 0; k < 9; k++) send_command(1'b1, '0, '0, k[0]);

    // Fill to capacity so full-heap drops and decreases under full occur.
    for (int k = 0; k < DEPTH; k++)
      send_command(1'b0, k[IDW-1:0], $urandom(), 1'b0);
    send_command(1'b0, 12'd4000, 32'sd0, 1'b0);
    send_command(1'b0, 12'd3, 32'sh80000000, 1'b0);
    for (int k = 0; k < 10; k++) send_command(1'b1, '0, '0, 1'b0);

    // Random: bursts of inserts with reused ids, then drains, mixed.
    n = 0;
    while (n < 60) begin
      live = $urandom_range(1, 40);
      for (int k = 0; k < live; k++) begin
        f = ($urandom_range(0, 3) == 0);
        id = ($urandom_range(0, 3) == 0) ? IDW'($urandom()) : IDW'($urandom_range(0, 63));
        send_command(f, id, pick_priority(), 1'b1);
        n++;
      end
      for (int k = $urandom_range(0, live + 4); k > 0; k--) begin
        send_command(1'b1, IDW'($urandom()), $urandom(), 1'b1);
        n++;
      end
    end
    start <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (board.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // Anything still pending at the end counts as a failure.
  always @(posedge clk) begin
    if (cycles == LIMIT - 1 && board.pending.size() != 0) board.errors++;
  end
endmodule
